FILE: design/frame_fcs_checker_length_finder_macros.svh
// ----------------------------------------------------------------------------
// Frame FCS checker / length finder: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_FCS_CHECKER_LENGTH_FINDER_MACROS_SVH
`define FRAME_FCS_CHECKER_LENGTH_FINDER_MACROS_SVH

// Clocked property, ignored while reset is high
`define FFCLF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too
`define FFCLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ffclf_pkg.sv
// ----------------------------------------------------------------------------
// ffclf_pkg
// Types, constants and the CRC-16 byte update for the FCS checker.
// ----------------------------------------------------------------------------
package ffclf_pkg;

  // first position that takes part in the CRC
  localparam logic [7:0] POS_CRC_START  = 8'd2;
  // first position at which a match is tested
  localparam logic [7:0] POS_FIRST_TEST = 8'd4;

  // one word in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } ffclf_item_t;

  // one result word
  typedef struct packed {
    logic        fcs_ok;
    logic        length_found;
    logic [7:0]  found_length;
    logic [15:0] computed_fcs;
  } ffclf_result_t;

  // reflected CRC-16 (0x8408), one nibble; q * 0x1081 as non-overlapping xors
  function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
    logic [3:0] q;
    q = crc[3:0] ^ nib;
    return {4'b0000, crc[15:4]} ^ {q, 12'd0} ^ {5'd0, q, 7'd0} ^ {12'd0, q};
  endfunction

  // low nibble first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    return crc_nibble(crc_nibble(crc, b[3:0]), b[7:4]);
  endfunction

endpackage

FILE: design/ffclf_in_stage.sv
// ----------------------------------------------------------------------------
// ffclf_in_stage
// Input register: holds one word until the frame tracker consumes it.
// ----------------------------------------------------------------------------
module ffclf_in_stage
  import ffclf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        advance,
  output ffclf_item_t item
);

  // free when empty or when the held word moves on this cycle
  assign data_ready = !item.valid || advance;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (data_ready) begin
      item.valid <= data_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      item.data <= data_byte;
      item.last <= last_byte;
    end
  end

endmodule

FILE: design/ffclf_frame_track.sv
// ----------------------------------------------------------------------------
// ffclf_frame_track
// Per-frame state: running CRC, CRC one byte back, position and first match.
// ----------------------------------------------------------------------------
module ffclf_frame_track
  import ffclf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  ffclf_item_t   item,
  output ffclf_result_t result
);

  localparam logic [7:0] POS_MAX = 8'(MAX_FRAME_BYTES - 1);

  logic [15:0] crc_running;
  logic [15:0] crc_before_last;
  logic [7:0]  previous_byte;
  logic [7:0]  byte_position;
  logic        match_seen;
  logic [7:0]  first_match_length;

  logic        hit;
  logic        match_seen_next;
  logic [7:0]  first_match_length_next;
  logic [15:0] crc_running_next;
  logic [7:0]  byte_position_next;

  // match test and next state
  always_comb begin
    hit = (byte_position >= POS_FIRST_TEST) &&
          (crc_before_last == {item.data, previous_byte});
    match_seen_next = match_seen || hit;
    first_match_length_next = (hit && !match_seen) ? (byte_position - 8'd1)
                                                   : first_match_length;
    crc_running_next = (byte_position >= POS_CRC_START) ? crc_byte(crc_running, item.data)
                                                        : crc_running;
    byte_position_next = (byte_position < POS_MAX) ? (byte_position + 8'd1) : byte_position;
  end

  // result for a last word
  always_comb begin
    result.fcs_ok       = hit;
    result.length_found = match_seen_next;
    result.found_length = match_seen_next ? first_match_length_next : 8'd0;
    result.computed_fcs = crc_before_last;
  end

  // frame state, cleared after each last word
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running        <= 16'd0;
      crc_before_last    <= 16'd0;
      byte_position      <= 8'd0;
      match_seen         <= 1'b0;
      first_match_length <= 8'd0;
    end else if (step) begin
      if (item.last) begin
        crc_running        <= 16'd0;
        crc_before_last    <= 16'd0;
        byte_position      <= 8'd0;
        match_seen         <= 1'b0;
        first_match_length <= 8'd0;
      end else begin
        crc_running        <= crc_running_next;
        crc_before_last    <= crc_running;
        byte_position      <= byte_position_next;
        match_seen         <= match_seen_next;
        first_match_length <= first_match_length_next;
      end
    end
  end

  // previous byte, only read from position 4 on
  always_ff @(posedge clk) begin
    if (step) begin
      previous_byte <= item.data;
    end
  end

endmodule

FILE: design/ffclf_out_stage.sv
// ----------------------------------------------------------------------------
// ffclf_out_stage
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
module ffclf_out_stage
  import ffclf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ffclf_result_t result,
  output logic          result_valid,
  input  logic          result_ready,
  output logic          fcs_ok,
  output logic          length_found,
  output logic [7:0]    found_length,
  output logic [15:0]   computed_fcs
);

  ffclf_result_t held;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign fcs_ok       = held.fcs_ok;
  assign length_found = held.length_found;
  assign found_length = held.found_length;
  assign computed_fcs = held.computed_fcs;

endmodule

FILE: design/frame_fcs_checker_length_finder.sv
// ----------------------------------------------------------------------------
// frame_fcs_checker_length_finder
// IEEE 802.15.4 FCS check (CRC-16 KERMIT) with first-match length search.
// ----------------------------------------------------------------------------
// Result path: a last word is accepted into the input register, then passes
//   the CRC/match logic into the result register, which raises result_valid;
//   the result word is held there until the consumer takes it.
// Throughput: one word per cycle; a last word waits only while the result
//   register is full and not being taken.
// Reset: synchronous, clears both valid bits and the per-frame CRC, position and match state.
module frame_fcs_checker_length_finder
  import ffclf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        fcs_ok,
  output logic        length_found,
  output logic [7:0]  found_length,
  output logic [15:0] computed_fcs
);

  ffclf_item_t   item;
  ffclf_result_t result;
  logic          advance;
  logic          step;

  // non-last words never need the result register
  assign advance = !item.last || !result_valid || result_ready;
  assign step    = item.valid && advance;

  ffclf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .item       (item)
  );

  ffclf_frame_track #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  ffclf_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step && item.last),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .fcs_ok       (fcs_ok),
    .length_found (length_found),
    .found_length (found_length),
    .computed_fcs (computed_fcs)
  );

endmodule

FILE: design/ffclf_checker.sv
// ----------------------------------------------------------------------------
// ffclf_checker
// Port-level checks on the result channel of the FCS checker.
// ----------------------------------------------------------------------------
`include "frame_fcs_checker_length_finder_macros.svh"

module ffclf_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic        fcs_ok,
  input logic        length_found,
  input logic [7:0]  found_length,
  input logic [15:0] computed_fcs
);

  // stalled word holds
  `FFCLF_ASSERT(a_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(fcs_ok) && $stable(length_found) && $stable(found_length) && $stable(computed_fcs), "result word changed while stalled")

  // a good FCS at the end is itself a match
  `FFCLF_ASSERT(a_ok_found, clk, rst, result_valid && fcs_ok |-> length_found, "fcs_ok without length_found")

  // no match reports a zero length, a match at least three
  `FFCLF_ASSERT(a_len_zero, clk, rst, result_valid && !length_found |-> found_length == 8'd0, "length set without a match")
  `FFCLF_ASSERT(a_len_min, clk, rst, result_valid && length_found |-> found_length >= 8'd3, "found length below first test position")

  // nothing pending right after reset
  `FFCLF_ASSERT_ALWAYS(a_rst_empty, clk, $past(rst) |-> !result_valid, "result valid after reset")

endmodule

bind frame_fcs_checker_length_finder ffclf_checker u_ffclf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .fcs_ok       (fcs_ok),
  .length_found (length_found),
  .found_length (found_length),
  .computed_fcs (computed_fcs)
);
